>>> src/assert_macros.svh
// assertion macros used by the checker file
// each macro clocks on clk and is disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on the following edge outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ipdt_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the frame builder for the ir pulse-distance transmitter
// no dependencies

package ipdt_pkg;

  localparam int FRAME_BITS = 16;
  localparam int CFG_W      = 14;
  localparam int IDX_W      = 3;
  localparam int FIELD_W    = 5;

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_HDR_MARK   = 3'd0;
  localparam logic [IDX_W-1:0] REG_HDR_SPACE  = 3'd1;
  localparam logic [IDX_W-1:0] REG_BIT_MARK   = 3'd2;
  localparam logic [IDX_W-1:0] REG_ONE_SPACE  = 3'd3;
  localparam logic [IDX_W-1:0] REG_ZERO_SPACE = 3'd4;
  localparam logic [IDX_W-1:0] REG_GAP        = 3'd5;

  // register reset values in ticks
  localparam logic [CFG_W-1:0] RST_HDR_MARK   = 14'd9000;
  localparam logic [CFG_W-1:0] RST_HDR_SPACE  = 14'd4500;
  localparam logic [CFG_W-1:0] RST_BIT_MARK   = 14'd560;
  localparam logic [CFG_W-1:0] RST_ONE_SPACE  = 14'd1690;
  localparam logic [CFG_W-1:0] RST_ZERO_SPACE = 14'd560;
  localparam logic [CFG_W-1:0] RST_GAP        = 14'd9000;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_HDR_MARK  = 3'd1,
    PH_HDR_SPACE = 3'd2,
    PH_BIT_MARK  = 3'd3,
    PH_BIT_SPACE = 3'd4,
    PH_STOP_MARK = 3'd5,
    PH_GAP       = 3'd6
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] header_mark_ticks;
    logic [CFG_W-1:0] header_space_ticks;
    logic [CFG_W-1:0] bit_mark_ticks;
    logic [CFG_W-1:0] one_space_ticks;
    logic [CFG_W-1:0] zero_space_ticks;
    logic [CFG_W-1:0] trailer_gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic               send_request;
    logic [FIELD_W-1:0] player_number;
    logic [FIELD_W-1:0] weapon_value;
  } item_t;

  typedef struct packed {
    logic led_mark;
    logic busy_res;
    logic accepted;
    logic frame_done;
  } result_t;

  // start bit, player, weapon, then their xor as a check field
  function automatic logic [FRAME_BITS-1:0] build_frame(
    input logic [FIELD_W-1:0] player,
    input logic [FIELD_W-1:0] weapon
  );
    build_frame = {player ^ weapon, weapon, player, 1'b1};
  endfunction

endpackage

>>> src/ipdt_cfg_regs.sv
`timescale 1ns / 1ps
// timing register file for the ir pulse-distance transmitter
// depends on ipdt_pkg

module ipdt_cfg_regs import ipdt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0] wr_data,
  output cfg_t             cfg
);

  // one register per index, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_mark_ticks  <= RST_HDR_MARK;
      cfg.header_space_ticks <= RST_HDR_SPACE;
      cfg.bit_mark_ticks     <= RST_BIT_MARK;
      cfg.one_space_ticks    <= RST_ONE_SPACE;
      cfg.zero_space_ticks   <= RST_ZERO_SPACE;
      cfg.trailer_gap_ticks  <= RST_GAP;
    end else if (wr_en) begin
      case (wr_index)
        REG_HDR_MARK:   cfg.header_mark_ticks  <= wr_data;
        REG_HDR_SPACE:  cfg.header_space_ticks <= wr_data;
        REG_BIT_MARK:   cfg.bit_mark_ticks     <= wr_data;
        REG_ONE_SPACE:  cfg.one_space_ticks    <= wr_data;
        REG_ZERO_SPACE: cfg.zero_space_ticks   <= wr_data;
        REG_GAP:        cfg.trailer_gap_ticks  <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

>>> src/ipdt_seq.sv
`timescale 1ns / 1ps
// envelope sequencer: phase, segment timer, bit counter and frame shifter
// depends on ipdt_pkg

module ipdt_seq import ipdt_pkg::*; #(
  parameter int TIMER_BITS = 14
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  localparam int LW = (TIMER_BITS < CFG_W) ? TIMER_BITS : CFG_W;
  localparam int BI_W = 5;

  phase_t                phase, phase_next;
  logic [TIMER_BITS-1:0] tick_counter, tick_counter_next;
  logic [BI_W-1:0]       bit_index, bit_index_next;
  logic [FRAME_BITS-1:0] frame_shift, frame_shift_next;

  logic                  is_idle, start, seg_end;
  phase_t                cur_phase;
  logic [TIMER_BITS-1:0] cur_count, len;
  logic [BI_W-1:0]       cur_bit, bit_inc;
  logic [FRAME_BITS-1:0] cur_shift;
  logic [CFG_W-1:0]      seg_raw;
  logic [TIMER_BITS:0]   count_inc;

  // segment length in the timer width, zero acts as one tick
  function automatic logic [TIMER_BITS-1:0] seg_len(input logic [CFG_W-1:0] r);
    logic [TIMER_BITS-1:0] v;
    v = TIMER_BITS'(r[LW-1:0]);
    seg_len = (v == '0) ? TIMER_BITS'(1) : v;
  endfunction

  // effective state for this beat, a request in idle starts the header at once
  always_comb begin
    is_idle   = !(phase inside {[PH_HDR_MARK:PH_GAP]});
    start     = is_idle && item.send_request;
    cur_phase = start ? PH_HDR_MARK : (is_idle ? PH_IDLE : phase);
    cur_shift = start ? build_frame(item.player_number, item.weapon_value) : frame_shift;
    cur_count = start ? '0 : tick_counter;
    cur_bit   = start ? '0 : bit_index;
  end

  // length of the running segment
  always_comb begin
    case (cur_phase)
      PH_HDR_MARK:  seg_raw = cfg.header_mark_ticks;
      PH_HDR_SPACE: seg_raw = cfg.header_space_ticks;
      PH_BIT_MARK:  seg_raw = cfg.bit_mark_ticks;
      PH_BIT_SPACE: seg_raw = cur_shift[0] ? cfg.one_space_ticks : cfg.zero_space_ticks;
      PH_STOP_MARK: seg_raw = cfg.bit_mark_ticks;
      default:      seg_raw = cfg.trailer_gap_ticks;
    endcase
    len       = seg_len(seg_raw);
    count_inc = {1'b0, cur_count} + (TIMER_BITS+1)'(1);
    seg_end   = count_inc >= {1'b0, len};
    bit_inc   = cur_bit + BI_W'(1);
  end

  // next state
  always_comb begin
    phase_next        = cur_phase;
    tick_counter_next = cur_count;
    bit_index_next    = cur_bit;
    frame_shift_next  = cur_shift;
    if (cur_phase != PH_IDLE) begin
      if (seg_end) begin
        tick_counter_next = '0;
        case (cur_phase)
          PH_HDR_MARK:  phase_next = PH_HDR_SPACE;
          PH_HDR_SPACE: phase_next = PH_BIT_MARK;
          PH_BIT_MARK:  phase_next = PH_BIT_SPACE;
          PH_BIT_SPACE: begin
            frame_shift_next = cur_shift >> 1;
            bit_index_next   = bit_inc;
            phase_next       = (32'(bit_inc) >= FRAME_BITS) ? PH_STOP_MARK : PH_BIT_MARK;
          end
          PH_STOP_MARK: phase_next = PH_GAP;
          default: begin
            phase_next     = PH_IDLE;
            bit_index_next = '0;
          end
        endcase
      end else begin
        tick_counter_next = count_inc[TIMER_BITS-1:0];
      end
    end
  end

  // outputs for this beat
  always_comb begin
    res.busy_res   = cur_phase != PH_IDLE;
    res.led_mark   = (cur_phase == PH_HDR_MARK) || (cur_phase == PH_BIT_MARK) ||
                     (cur_phase == PH_STOP_MARK);
    res.accepted   = start;
    res.frame_done = (cur_phase == PH_GAP) && seg_end;
  end

  // state advances once per processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_counter <= '0;
      bit_index    <= '0;
      frame_shift  <= '0;
    end else if (step) begin
      phase        <= phase_next;
      tick_counter <= tick_counter_next;
      bit_index    <= bit_index_next;
      frame_shift  <= frame_shift_next;
    end
  end

endmodule

>>> src/ir_pulse_distance_transmitter_top.sv
`timescale 1ns / 1ps
// Top level of the ir pulse-distance transmitter.
// Each input beat is one time tick: send_request, player_number, weapon_value.
// Each tick yields one output beat: led_mark, busy_res, accepted, frame_done.
// A request in idle builds a 16-bit frame and sends it lsb first as header
// mark, header space, per bit a mark and a short or long space, a stop mark
// and a trailing low gap; requests made while busy are refused.
// Channels use valid/stall; a beat moves when valid is high and stall low.
// Timing registers are written through cfg_valid/cfg_ready (always ready),
// cfg_index selecting the register and cfg_data giving its tick count.
// A taken input beat waits in the input register, and its result is
// registered in the output register. Throughput: one tick per cycle, no
// gap while out_stall is low; input and output register hold a beat each.
// A stall on the output holds the result and, once the input register is
// full too, raises in_stall; no beat is lost or repeated.
// Reset empties both registers, returns the sequencer to idle and reloads
// the default timings.
// depends on ipdt_pkg, ipdt_cfg_regs, ipdt_seq

module ir_pulse_distance_transmitter_top import ipdt_pkg::*; #(
  parameter int TIMER_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               send_request,
  input  logic [FIELD_W-1:0] player_number,
  input  logic [FIELD_W-1:0] weapon_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               led_mark,
  output logic               busy_res,
  output logic               accepted,
  output logic               frame_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  cfg_t    cfg;
  item_t   in_q;
  logic    in_q_valid;
  result_t res, out_q;
  logic    move, in_take;

  assign cfg_ready = 1'b1;

  ipdt_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // handshake between input register, sequencer and output register
  assign move     = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !move;
  assign in_take  = in_valid && !in_stall;

  ipdt_seq #(.TIMER_BITS(TIMER_BITS)) u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (move),
    .item (in_q),
    .cfg  (cfg),
    .res  (res)
  );

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (move) begin
      in_q_valid <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q.send_request  <= send_request;
      in_q.player_number <= player_number;
      in_q.weapon_value  <= weapon_value;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (move) begin
      out_q <= res;
    end
  end

  assign led_mark   = out_q.led_mark;
  assign busy_res   = out_q.busy_res;
  assign accepted   = out_q.accepted;
  assign frame_done = out_q.frame_done;

endmodule

>>> src/ipdt_checker.sv
`timescale 1ns / 1ps
// port-level checker for the ir pulse-distance transmitter, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module ipdt_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic led_mark,
  input logic busy_res,
  input logic accepted,
  input logic frame_done
);

  // a stalled result beat stays put
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({led_mark, busy_res, accepted, frame_done}), "result beat changed while stalled")

  // a started frame begins with the header mark
  `ASSERT_CLK(a_start_mark, !(out_valid && accepted) || (busy_res && led_mark), "accepted beat not in header mark")

  // frame end falls in the low gap
  `ASSERT_CLK(a_done_gap, !(out_valid && frame_done) || (busy_res && !led_mark && !accepted), "frame_done outside the trailing gap")

  // idle beats keep the led off
  `ASSERT_CLK(a_idle_quiet, !(out_valid && !busy_res) || (!led_mark && !frame_done), "idle beat shows activity")

endmodule

bind ir_pulse_distance_transmitter_top ipdt_checker u_ipdt_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .led_mark   (led_mark),
  .busy_res   (busy_res),
  .accepted   (accepted),
  .frame_done (frame_done)
);

>>> tb/ir_pulse_distance_transmitter_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for ir_pulse_distance_transmitter_top: one tick per beat,
// envelope predicted per tick and compared against the output beats
// depends on ipdt_pkg and the transmitter rtl

module ir_pulse_distance_transmitter_top_tb;
  import ipdt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_TICKS  = 580;
  localparam int SHOW_LIMIT  = 10;
  localparam int SETTLE_CYC  = 4;

  // indexes past the last timing register, writes there are dropped
  localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

  // timing sets loaded ahead of a directed row
  typedef enum logic [2:0] {
    PRE_NONE,
    PRE_ZERO,
    PRE_FAST,
    PRE_MIXED,
    PRE_LONG_HDR,
    PRE_LONG_GAP,
    PRE_RETIME
  } preset_t;

  typedef struct packed {
    preset_t            pre;
    logic               req;
    logic [FIELD_W-1:0] pl;
    logic [FIELD_W-1:0] wp;
    logic               typed;
    result_t            want;
  } plan_row_t;

  localparam int PLAN_ROWS = 18;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               send_request = 1'b0;
  logic [FIELD_W-1:0] player_number = '0;
  logic [FIELD_W-1:0] weapon_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               led_mark;
  logic               busy_res;
  logic               accepted;
  logic               frame_done;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  // envelope predictor state
  cfg_t                 timing;
  phase_t               tx_phase;
  int                   seg_spent;
  logic [4:0]           bits_done;
  logic [FRAME_BITS-1:0] shift_out;

  result_t   envelope_due[$];
  plan_row_t plan [PLAN_ROWS];
  int        fails = 0;
  int        shown = 0;
  int        cycle_cnt = 0;
  int        burst_left = 0;
  logic [1:0] stall_mode = 2'd0;

  ir_pulse_distance_transmitter_top uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .send_request  (send_request),
    .player_number (player_number),
    .weapon_value  (weapon_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .led_mark      (led_mark),
    .busy_res      (busy_res),
    .accepted      (accepted),
    .frame_done    (frame_done),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  // cycle budget
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[ir_pulse_distance_transmitter_top] ERROR");
      $finish;
    end
  end

  // receiver stall pattern, mode redrawn whenever the low byte of cycle_cnt is zero
  always @(posedge clk) begin
    if (cycle_cnt[7:0] == 8'd0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= (cycle_cnt % 3 == 0);
    endcase
  end

  // frame word: start bit, player, weapon, check field
  function automatic logic [FRAME_BITS-1:0] frame_word(input logic [FIELD_W-1:0] pl,
                                                        input logic [FIELD_W-1:0] wp);
    logic [FRAME_BITS-1:0] f;
    f = '0;
    f[0] = 1'b1;
    f[5:1] = pl;
    f[10:6] = wp;
    f[15:11] = pl ^ wp;
    return f;
  endfunction

  // a zero count still lasts one tick
  function automatic int seg_ticks(input logic [CFG_W-1:0] v);
    return (v == '0) ? 1 : int'(v);
  endfunction

  function automatic int current_seg();
    case (tx_phase)
      PH_HDR_MARK:  return seg_ticks(timing.header_mark_ticks);
      PH_HDR_SPACE: return seg_ticks(timing.header_space_ticks);
      PH_BIT_MARK:  return seg_ticks(timing.bit_mark_ticks);
      PH_BIT_SPACE: return shift_out[0] ? seg_ticks(timing.one_space_ticks)
                                        : seg_ticks(timing.zero_space_ticks);
      PH_STOP_MARK: return seg_ticks(timing.bit_mark_ticks);
      default:      return seg_ticks(timing.trailer_gap_ticks);
    endcase
  endfunction

  // one tick of the envelope sequencer
  function automatic result_t advance_envelope(input item_t it);
    result_t res;
    int      len;
    res = '0;
    if (tx_phase == PH_IDLE && it.send_request) begin
      shift_out = frame_word(it.player_number, it.weapon_value);
      bits_done = '0;
      seg_spent = 0;
      tx_phase = PH_HDR_MARK;
      res.accepted = 1'b1;
    end
    if (tx_phase != PH_IDLE) begin
      len = current_seg();
      res.busy_res = 1'b1;
      res.led_mark = (tx_phase == PH_HDR_MARK) || (tx_phase == PH_BIT_MARK) ||
                     (tx_phase == PH_STOP_MARK);
      if (seg_spent + 1 >= len) begin
        seg_spent = 0;
        case (tx_phase)
          PH_HDR_MARK:  tx_phase = PH_HDR_SPACE;
          PH_HDR_SPACE: tx_phase = PH_BIT_MARK;
          PH_BIT_MARK:  tx_phase = PH_BIT_SPACE;
          PH_BIT_SPACE: begin
            shift_out = shift_out >> 1;
            bits_done = bits_done + 5'd1;
            if (bits_done >= FRAME_BITS) tx_phase = PH_STOP_MARK;
            else tx_phase = PH_BIT_MARK;
          end
          PH_STOP_MARK: tx_phase = PH_GAP;
          default: begin
            tx_phase = PH_IDLE;
            bits_done = '0;
            res.frame_done = 1'b1;
          end
        endcase
      end else begin
        seg_spent = seg_spent + 1;
      end
    end
    return res;
  endfunction

  // requests mostly where they start a frame or land on the gap
  function automatic item_t random_tick();
    item_t it;
    int    pct;
    it.player_number = FIELD_W'($urandom);
    it.weapon_value  = FIELD_W'($urandom);
    case (tx_phase)
      PH_IDLE: pct = 75;
      PH_GAP:  pct = 70;
      default: pct = 20;
    endcase
    it.send_request = ($urandom_range(0, 99) < pct);
    return it;
  endfunction

  function automatic logic [CFG_W-1:0] random_count();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r < 13) return CFG_W'($urandom_range(1, 3));
    return CFG_W'($urandom_range(4, 20));
  endfunction

  function automatic cfg_t preset_timing(input preset_t p);
    cfg_t c;
    case (p)
      PRE_ZERO: c = '0;
      PRE_MIXED: begin
        c.header_mark_ticks  = 14'd3;
        c.header_space_ticks = 14'd2;
        c.bit_mark_ticks     = 14'd1;
        c.one_space_ticks    = 14'd4;
        c.zero_space_ticks   = 14'd2;
        c.trailer_gap_ticks  = 14'd3;
      end
      PRE_LONG_HDR: begin
        c = {6{14'd1}};
        c.header_mark_ticks = 14'd16383;
      end
      PRE_LONG_GAP: begin
        c = {6{14'd2}};
        c.header_space_ticks = 14'd16383;
        c.trailer_gap_ticks  = 14'd16383;
      end
      default: c = {6{14'd1}};
    endcase
    return c;
  endfunction

  // one input beat; the predictor runs at the accepting edge
  task automatic drive_tick(input item_t it, input logic typed, input result_t want,
                            output result_t res);
    int   gap;
    logic took;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left = burst_left - 1;
    in_valid      <= 1'b1;
    send_request  <= it.send_request;
    player_number <= it.player_number;
    weapon_value  <= it.weapon_value;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    res = advance_envelope(it);
    if (typed) res = want;
    envelope_due.push_back(res);
  endtask

  // run the current frame out to idle
  task automatic finish_frame();
    result_t r;
    while (tx_phase != PH_IDLE) drive_tick(random_tick(), 1'b0, '0, r);
  endtask

  // sender holds off until every beat has come back
  task automatic drain_beats();
    in_valid <= 1'b0;
    while (envelope_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_timing(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    logic took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    case (idx)
      REG_HDR_MARK:   timing.header_mark_ticks  = val;
      REG_HDR_SPACE:  timing.header_space_ticks = val;
      REG_BIT_MARK:   timing.bit_mark_ticks     = val;
      REG_ONE_SPACE:  timing.one_space_ticks    = val;
      REG_ZERO_SPACE: timing.zero_space_ticks   = val;
      REG_GAP:        timing.trailer_gap_ticks  = val;
      default: ;
    endcase
  endtask

  task automatic load_timings(input cfg_t c);
    write_timing(REG_HDR_MARK,   c.header_mark_ticks);
    write_timing(REG_HDR_SPACE,  c.header_space_ticks);
    write_timing(REG_BIT_MARK,   c.bit_mark_ticks);
    write_timing(REG_ONE_SPACE,  c.one_space_ticks);
    write_timing(REG_ZERO_SPACE, c.zero_space_ticks);
    write_timing(REG_GAP,        c.trailer_gap_ticks);
    write_timing(REG_SPARE_A,    CFG_W'($urandom_range(0, 16383)));
    write_timing(REG_SPARE_B,    CFG_W'($urandom_range(0, 16383)));
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_preset(input preset_t p);
    if (p == PRE_RETIME) begin
      // stretch the bit mark while it is running
      drain_beats();
      write_timing(REG_BIT_MARK, 14'd4);
      cfg_valid <= 1'b0;
    end else if (p != PRE_NONE) begin
      // cut a running frame short with one-tick segments, then load the set
      drain_beats();
      load_timings(preset_timing(PRE_FAST));
      finish_frame();
      drain_beats();
      load_timings(preset_timing(p));
    end
  endtask

  // output beat check, sampled on the falling edge ahead of the accepting edge
  always @(negedge clk) begin
    result_t want;
    logic    bad;
    if (!rst && out_valid && !out_stall) begin
      if (envelope_due.size() == 0) begin
        fails = fails + 1;
        if (shown < SHOW_LIMIT) begin
          shown = shown + 1;
          $display("unexpected output beat: led=%0b busy=%0b acc=%0b done=%0b",
                   led_mark, busy_res, accepted, frame_done);
        end
      end else begin
        want = envelope_due.pop_front();
        bad = (led_mark !== want.led_mark) || (busy_res !== want.busy_res) ||
              (accepted !== want.accepted) || (frame_done !== want.frame_done);
        if (bad) begin
          fails = fails + 1;
          if (shown < SHOW_LIMIT) begin
            shown = shown + 1;
            $display("tick mismatch: want led=%0b busy=%0b acc=%0b done=%0b, got %0b %0b %0b %0b",
                     want.led_mark, want.busy_res, want.accepted, want.frame_done,
                     led_mark, busy_res, accepted, frame_done);
          end
        end
      end
    end
  end

  initial begin
    item_t   it;
    result_t r;
    int      rand_ticks;
    int      i;

    // directed rows: idle after reset, default start, refusal, zero and extreme timings
    plan = '{
      '{PRE_NONE,     1'b0, 5'd0,  5'd0,  1'b1, 4'b0000},
      '{PRE_NONE,     1'b0, 5'd31, 5'd31, 1'b1, 4'b0000},
      '{PRE_NONE,     1'b1, 5'd0,  5'd0,  1'b1, 4'b1110},
      '{PRE_NONE,     1'b1, 5'd31, 5'd31, 1'b1, 4'b1100},
      '{PRE_ZERO,     1'b1, 5'd31, 5'd0,  1'b1, 4'b1110},
      '{PRE_NONE,     1'b1, 5'd0,  5'd31, 1'b1, 4'b0100},
      '{PRE_NONE,     1'b0, 5'd21, 5'd10, 1'b0, 4'b0000},
      '{PRE_FAST,     1'b1, 5'd0,  5'd31, 1'b1, 4'b1110},
      '{PRE_NONE,     1'b0, 5'd5,  5'd5,  1'b1, 4'b0100},
      '{PRE_RETIME,   1'b0, 5'd1,  5'd2,  1'b1, 4'b1100},
      '{PRE_NONE,     1'b1, 5'd10, 5'd21, 1'b0, 4'b0000},
      '{PRE_MIXED,    1'b1, 5'd21, 5'd10, 1'b0, 4'b0000},
      '{PRE_NONE,     1'b0, 5'd16, 5'd1,  1'b0, 4'b0000},
      '{PRE_LONG_HDR, 1'b1, 5'd31, 5'd31, 1'b1, 4'b1110},
      '{PRE_NONE,     1'b1, 5'd0,  5'd0,  1'b1, 4'b1100},
      '{PRE_LONG_GAP, 1'b1, 5'd10, 5'd21, 1'b1, 4'b1110},
      '{PRE_NONE,     1'b0, 5'd31, 5'd0,  1'b0, 4'b0000},
      '{PRE_FAST,     1'b1, 5'd31, 5'd31, 1'b1, 4'b1110}
    };

    // predictor reset image
    timing.header_mark_ticks  = RST_HDR_MARK;
    timing.header_space_ticks = RST_HDR_SPACE;
    timing.bit_mark_ticks     = RST_BIT_MARK;
    timing.one_space_ticks    = RST_ONE_SPACE;
    timing.zero_space_ticks   = RST_ZERO_SPACE;
    timing.trailer_gap_ticks  = RST_GAP;
    tx_phase  = PH_IDLE;
    seg_spent = 0;
    bits_done = '0;
    shift_out = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part
    for (i = 0; i < PLAN_ROWS; i++) begin
      apply_preset(plan[i].pre);
      it.send_request  = plan[i].req;
      it.player_number = plan[i].pl;
      it.weapon_value  = plan[i].wp;
      drive_tick(it, plan[i].typed, plan[i].want, r);
    end
    finish_frame();
    drain_beats();
    load_timings({random_count(), random_count(), random_count(),
                  random_count(), random_count(), random_count()});

    // random part, retimed now and then between frames
    rand_ticks = 0;
    while (rand_ticks < RAND_TICKS) begin
      it = random_tick();
      if (tx_phase != PH_IDLE || it.send_request) rand_ticks++;
      drive_tick(it, 1'b0, '0, r);
      if (r.frame_done && $urandom_range(0, 2) == 0) begin
        drain_beats();
        load_timings({random_count(), random_count(), random_count(),
                      random_count(), random_count(), random_count()});
      end
    end

    in_valid <= 1'b0;
    while (envelope_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("[ir_pulse_distance_transmitter_top] OK");
    end else begin
      $display("[ir_pulse_distance_transmitter_top] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/ipdt_pkg.sv
src/ipdt_cfg_regs.sv
src/ipdt_seq.sv
src/ir_pulse_distance_transmitter_top.sv
src/ipdt_checker.sv
tb/ir_pulse_distance_transmitter_top_tb.sv
